// File: sv/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types, field widths and operation codes of the bitmap range
// allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

	// default geometry of the map
	localparam int DEF_MAX_BITS  = 4096;
	localparam int DEF_WORD_BITS = 32;

	// request and response field widths
	localparam int OP_W   = 3;
	localparam int IDX_W  = 12;
	localparam int LEN_W  = 13;
	localparam int SIZE_W = 13;
	localparam int CNT_W  = 13;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_SIZE = 1'b0;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

	// operation codes
	localparam logic [OP_W-1:0] OP_SET    = 3'd0;
	localparam logic [OP_W-1:0] OP_CLR    = 3'd1;
	localparam logic [OP_W-1:0] OP_ALLOC  = 3'd2;
	localparam logic [OP_W-1:0] OP_TSET   = 3'd3;
	localparam logic [OP_W-1:0] OP_TCLR   = 3'd4;
	localparam logic [OP_W-1:0] OP_COUNT  = 3'd5;
	localparam logic [OP_W-1:0] OP_CLRALL = 3'd6;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] first_bit;
		logic [LEN_W-1:0] run_length;
	} bra_req_t;

	typedef struct packed {
		logic             alloc_ok;
		logic [IDX_W-1:0] found_index;
		logic             range_matches;
		logic [CNT_W-1:0] set_count;
		logic [CNT_W-1:0] clear_count;
	} bra_rsp_t;

	// per-word verdict from the word evaluator
	typedef struct packed {
		logic found;
		logic match;
	} bra_eval_t;

endpackage

// File: sv/bra_word_eval.sv
// ----------------------------------------------------------------------------
// bra_word_eval
// Evaluates one map word against the active bit range: masked update for
// fills, all-equal test, population count and the clear-run search step.
// ----------------------------------------------------------------------------
module bra_word_eval import bra_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS,
	parameter int PW        = LEN_W
) (
	input  logic [WORD_BITS-1:0]          word,
	input  logic                          word_vld,
	input  logic [PW-1:0]                 base,
	input  logic [PW-1:0]                 lo,
	input  logic [PW-1:0]                 hi,
	input  logic [PW-1:0]                 len,
	input  logic [PW-1:0]                 run_in,
	input  logic                          val,
	output logic [WORD_BITS-1:0]          new_word,
	output logic [$clog2(WORD_BITS+1)-1:0] pop,
	output logic [PW-1:0]                 pos,
	output logic [PW-1:0]                 run_out,
	output bra_eval_t                     status
);

	localparam int OW = $clog2(WORD_BITS + 1);
	localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

	// offset of an absolute bit position inside this word, clamped to 0..WORD_BITS
	function automatic logic [OW-1:0] rel_off(input logic [PW-1:0] x,
		input logic [PW-1:0] b);
		logic [PW-1:0] d;
		d = x - b;
		if (x <= b) begin
			return '0;
		end
		if (d >= PW'(WORD_BITS)) begin
			return OW'(WORD_BITS);
		end
		return d[OW-1:0];
	endfunction

	// bit i set where bits i..i+n-1 are all free, built from doubling windows
	function automatic logic [WORD_BITS-1:0] run_starts(input logic [WORD_BITS-1:0] z,
		input logic [OW-1:0] n);
		logic [WORD_BITS-1:0] p;
		logic [WORD_BITS-1:0] acc;
		logic [OW:0]          s;
		p   = z;
		acc = '1;
		s   = '0;
		for (int k = 0; k < OW; k++) begin
			if (n[k]) begin
				acc = acc & (p >> s);
				s   = s + (OW+1)'(1 << k);
			end
			p = p & (p >> (1 << k));
		end
		return acc;
	endfunction

	function automatic logic [OW-1:0] trail_ones(input logic [WORD_BITS-1:0] v);
		logic [OW-1:0] c;
		c = OW'(WORD_BITS);
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!v[i]) begin
				c = OW'(i);
			end
		end
		return c;
	endfunction

	function automatic logic [OW-1:0] lead_ones(input logic [WORD_BITS-1:0] v);
		logic [OW-1:0] c;
		c = OW'(WORD_BITS);
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!v[i]) begin
				c = OW'(WORD_BITS - 1 - i);
			end
		end
		return c;
	endfunction

	function automatic logic [OW-1:0] first_set(input logic [WORD_BITS-1:0] v);
		logic [OW-1:0] c;
		c = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				c = OW'(i);
			end
		end
		return c;
	endfunction

	function automatic logic [OW-1:0] pop_count(input logic [WORD_BITS-1:0] v);
		logic [OW-1:0] c;
		c = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			c = c + OW'(v[i]);
		end
		return c;
	endfunction

	logic [WORD_BITS-1:0] bits;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] free;
	logic [WORD_BITS-1:0] starts;
	logic [OW-1:0]        lo_rel;
	logic [OW-1:0]        hi_rel;
	logic [OW-1:0]        tz;
	logic                 len_small;
	logic                 cross_hit;

	// never-written words read as all clear
	assign bits   = word_vld ? word : '0;
	assign lo_rel = rel_off(lo, base);
	assign hi_rel = rel_off(hi, base);
	assign mask   = (ALL_ONES << lo_rel) & ~(ALL_ONES << hi_rel);

	// fill, test and count
	assign new_word     = val ? (bits | mask) : (bits & ~mask);
	assign status.match = ((bits & mask) == (val ? mask : '0));
	assign pop          = pop_count(bits & mask);

	// run search: free bits are clear bits inside the range
	assign free      = ~bits & mask;
	assign tz        = trail_ones(free);
	assign len_small = (len <= PW'(WORD_BITS));
	assign starts    = len_small ? run_starts(free, len[OW-1:0]) : '0;
	assign cross_hit = (run_in != '0)
		&& (({1'b0, run_in} + (PW+1)'(tz)) >= {1'b0, len});

	assign status.found = cross_hit || (starts != '0);
	assign pos          = cross_hit ? (base - run_in) : (base + PW'(first_set(starts)));
	assign run_out      = (&free) ? (run_in + PW'(WORD_BITS)) : PW'(lead_ones(free));

endmodule

// File: sv/bitmap_range_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_range_allocator_unit: bitmap range allocator, one word of the map per cycle
// Flow: a request goes from prepare straight to done when no word is touched, else through
// locate, base and walk; each extra allocate pass (wrap, fill) repeats locate, base and walk.
// One item at a time; the map RAM read port and its single walk sequencer set the rate.
// Reset: map reads as all clear through per-word valid flags, size in use is 4096.
// ----------------------------------------------------------------------------
module bitmap_range_allocator_unit import bra_pkg::*; #(
	parameter int MAX_BITS  = DEF_MAX_BITS,
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  bra_req_t          req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bra_rsp_t          rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	// wide enough for a first bit plus any run length
	localparam int PW        = ($clog2(MAX_BITS) + 2 > LEN_W + 1)
		? $clog2(MAX_BITS) + 2 : LEN_W + 1;
	localparam int OW        = $clog2(WORD_BITS + 1);
	localparam int SHIFT     = PW + $clog2(WORD_BITS);
	localparam int PRODW     = 2 * PW + 2;
	localparam longint RECIP = ((longint'(1) << SHIFT) + WORD_BITS - 1) / WORD_BITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREP   = 3'd1;
	localparam logic [2:0] ST_LOCATE = 3'd2;
	localparam logic [2:0] ST_BASE   = 3'd3;
	localparam logic [2:0] ST_WALK   = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	localparam logic [1:0] PASS_FIRST = 2'd0;
	localparam logic [1:0] PASS_WRAP  = 2'd1;
	localparam logic [1:0] PASS_FILL  = 2'd2;

	logic [2:0]          state_q;
	logic [1:0]          pass_q;
	logic [OP_W-1:0]     op_q;
	logic [IDX_W-1:0]    start_q;
	logic [PW-1:0]       len_q;
	logic [PW-1:0]       lo_q;
	logic [PW-1:0]       hi_q;
	logic [PW-1:0]       base_q;
	logic [PW-1:0]       run_q;
	logic [PW-1:0]       cnt_q;
	logic [PW-1:0]       pos_q;
	logic [AW-1:0]       wa_q;
	logic                ok_q;
	logic                match_q;
	logic [SIZE_W-1:0]   size_q;
	logic [NUM_WORDS-1:0] vld_q;
	bra_rsp_t            rsp_q;
	logic                rsp_v_q;

	logic                 v_s1;
	logic [AW-1:0]        addr_s1;
	logic [PW-1:0]        base_s1;
	logic                 vld_s1;
	logic [WORD_BITS-1:0] rd_s1;

	logic [WORD_BITS-1:0] map_mem [NUM_WORDS];

	logic [PW-1:0]        used;
	logic [PW-1:0]        start_w;
	logic [PW-1:0]        sum_sl;
	logic [PW-1:0]        fill_lo;
	logic [PW-1:0]        fill_hi;
	logic [PRODW-1:0]     prod;
	logic [AW-1:0]        first_word;
	logic [PW-1:0]        word_base;
	logic                 search_mode;
	logic                 fill_mode;
	logic                 ev_val;
	logic                 stop;
	logic                 issue;
	logic                 wr_en;
	logic                 pass_end;
	logic                 load;
	logic                 cfg_wr;
	bra_rsp_t             rsp_n;

	logic [WORD_BITS-1:0] ev_word;
	logic [OW-1:0]        ev_pop;
	logic [PW-1:0]        ev_pos;
	logic [PW-1:0]        ev_run;
	bra_eval_t            ev;

	// size in use saturates at the map size
	assign used    = (PW'(size_q) > PW'(MAX_BITS)) ? PW'(MAX_BITS) : PW'(size_q);
	assign start_w = PW'(start_q);
	assign sum_sl  = start_w + len_q;
	assign fill_lo = (op_q == OP_CLRALL) ? '0 : start_w;
	assign fill_hi = (op_q == OP_CLRALL || sum_sl > used) ? used : sum_sl;

	// first word of the range by reciprocal multiply, then its first bit
	assign prod       = PRODW'(lo_q) * PRODW'(RECIP);
	assign first_word = AW'(prod >> SHIFT);
	assign word_base  = PW'(wa_q) * PW'(WORD_BITS);

	// walk control
	assign search_mode = (op_q == OP_ALLOC) && (pass_q != PASS_FILL);
	assign fill_mode   = (op_q inside {OP_SET, OP_CLR, OP_CLRALL})
		|| ((op_q == OP_ALLOC) && (pass_q == PASS_FILL));
	assign ev_val      = op_q inside {OP_SET, OP_ALLOC, OP_TSET};
	assign stop        = v_s1 && search_mode && ev.found;
	assign issue       = (state_q == ST_WALK) && (base_q < hi_q) && !stop;
	assign wr_en       = (state_q == ST_WALK) && v_s1 && fill_mode;
	assign pass_end    = (state_q == ST_WALK) && !v_s1 && !(base_q < hi_q);
	assign load        = (state_q == ST_DONE) && (!rsp_v_q || rsp_ready);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[APB_AW-1] == REG_SIZE) ? APB_DW'(size_q) : '0;

	bra_word_eval #(
		.WORD_BITS(WORD_BITS),
		.PW       (PW)
	) u_eval (
		.word    (rd_s1),
		.word_vld(vld_s1),
		.base    (base_s1),
		.lo      (lo_q),
		.hi      (hi_q),
		.len     (len_q),
		.run_in  (run_q),
		.val     (ev_val),
		.new_word(ev_word),
		.pop     (ev_pop),
		.pos     (ev_pos),
		.run_out (ev_run),
		.status  (ev)
	);

	// map RAM: one read and one write port, registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[addr_s1] <= ev_word;
		end
		if (issue) begin
			rd_s1 <= map_mem[wa_q];
		end
	end

	// result fields, zero where the op produces none
	always_comb begin
		rsp_n = '0;
		case (op_q)
			OP_ALLOC: begin
				rsp_n.alloc_ok    = ok_q;
				rsp_n.found_index = ok_q ? pos_q[IDX_W-1:0] : '0;
			end
			OP_TSET, OP_TCLR: begin
				rsp_n.range_matches = match_q;
			end
			OP_COUNT: begin
				rsp_n.set_count   = cnt_q[CNT_W-1:0];
				rsp_n.clear_count = CNT_W'(used - cnt_q);
			end
			default: begin
				rsp_n = '0;
			end
		endcase
	end

	// hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (load) begin
			rsp_v_q <= 1'b1;
			rsp_q   <= rsp_n;
		end else if (rsp_ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	// size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_wr && paddr[APB_AW-1] == REG_SIZE) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	// read stage and word valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			vld_q <= '0;
		end else begin
			v_s1 <= issue;
			if (issue) begin
				addr_s1 <= wa_q;
				base_s1 <= base_q;
				vld_s1  <= vld_q[wa_q];
			end
			if (wr_en) begin
				vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= PASS_FIRST;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q    <= req.op;
						start_q <= req.first_bit;
						len_q   <= PW'(req.run_length);
						pass_q  <= PASS_FIRST;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					case (op_q)
						OP_SET, OP_CLR, OP_CLRALL: begin
							lo_q    <= fill_lo;
							hi_q    <= fill_hi;
							state_q <= (fill_lo < fill_hi) ? ST_LOCATE : ST_DONE;
						end
						OP_TSET, OP_TCLR: begin
							lo_q <= start_w;
							hi_q <= sum_sl;
							if (len_q == '0 || start_w >= used || sum_sl > used) begin
								match_q <= 1'b0;
								state_q <= ST_DONE;
							end else begin
								match_q <= 1'b1;
								state_q <= ST_LOCATE;
							end
						end
						OP_COUNT: begin
							cnt_q   <= '0;
							lo_q    <= '0;
							hi_q    <= used;
							state_q <= (used == '0) ? ST_DONE : ST_LOCATE;
						end
						OP_ALLOC: begin
							ok_q  <= 1'b0;
							pos_q <= '0;
							run_q <= '0;
							hi_q  <= used;
							if (len_q > used) begin
								state_q <= ST_DONE;
							end else if (len_q == '0) begin
								// empty run: succeed at the hint, else at zero if the size in use is not zero
								state_q <= ST_DONE;
								if (start_w < used) begin
									ok_q  <= 1'b1;
									pos_q <= start_w;
								end else if (used != '0) begin
									ok_q <= 1'b1;
								end
							end else if (start_w < used) begin
								lo_q    <= start_w;
								state_q <= ST_LOCATE;
							end else begin
								pass_q  <= PASS_WRAP;
								lo_q    <= '0;
								state_q <= ST_LOCATE;
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_LOCATE: begin
					wa_q    <= first_word;
					state_q <= ST_BASE;
				end
				ST_BASE: begin
					base_q  <= word_base;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					// advance the read address
					if (issue) begin
						wa_q   <= wa_q + AW'(1);
						base_q <= base_q + PW'(WORD_BITS);
					end
					// fold in the word that just came back
					if (v_s1) begin
						if (op_q == OP_TSET || op_q == OP_TCLR) begin
							match_q <= match_q & ev.match;
						end
						if (op_q == OP_COUNT) begin
							cnt_q <= cnt_q + PW'(ev_pop);
						end
						if (search_mode) begin
							if (ev.found) begin
								ok_q    <= 1'b1;
								pos_q   <= ev_pos;
								lo_q    <= ev_pos;
								hi_q    <= ev_pos + len_q;
								pass_q  <= PASS_FILL;
								state_q <= ST_LOCATE;
							end else begin
								run_q <= ev_run;
							end
						end
					end
					// pass exhausted: wrap the search to zero or finish
					if (pass_end) begin
						if (search_mode && pass_q == PASS_FIRST && start_q != '0) begin
							pass_q  <= PASS_WRAP;
							lo_q    <= '0;
							run_q   <= '0;
							state_q <= ST_LOCATE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// writes stay below the size in use
	a_wr_in_size: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (base_s1 < used))
		else $error("map write beyond size in use");

	// the next read never hits the word being written back
	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && wr_en) |-> (wa_q != addr_s1))
		else $error("read overlaps write-back of the same word");

	// an allocated run lies inside the size in use
	a_alloc_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(load && op_q == OP_ALLOC && ok_q)
		|-> (((PW+1)'(pos_q) + (PW+1)'(len_q)) <= (PW+1)'(used)))
		else $error("allocated run exceeds size in use");
`endif

endmodule
